### hdl/pid_pkg.sv
// ----------------------------------------------------------------------------
// pid_pkg
// shared types and constants for the positional insert/delete array
// ----------------------------------------------------------------------------
package pid_pkg;

   localparam int CAPACITY   = 16;
   localparam int DATA_WIDTH = 32;
   localparam int OP_WIDTH   = 4;
   localparam int POS_WIDTH  = 5;
   localparam int IDX_WIDTH  = 4;
   localparam int CNT_WIDTH  = 5;
   localparam int ST_WIDTH   = 3;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_INSERT_AT    = 4'd0,
      OP_INSERT_FRONT = 4'd1,
      OP_INSERT_BACK  = 4'd2,
      OP_REMOVE_AT    = 4'd3,
      OP_REMOVE_FRONT = 4'd4,
      OP_REMOVE_BACK  = 4'd5,
      OP_READ         = 4'd6,
      OP_FIND_FIRST   = 4'd7,
      OP_FIND_ALL     = 4'd8
   } op_type;

   typedef enum logic [ST_WIDTH-1:0] {
      STATUS_OK        = 3'd0,
      STATUS_FULL      = 3'd1,
      STATUS_EMPTY     = 3'd2,
      STATUS_BAD_POS   = 3'd3,
      STATUS_NOT_FOUND = 3'd4
   } status_type;

   typedef struct packed {
      logic                  ins;
      logic                  rem;
      logic [CNT_WIDTH-1:0]  pos;
      logic [CNT_WIDTH-1:0]  count;
      logic [DATA_WIDTH-1:0] value;
   } cell_ctrl_type;

endpackage

### hdl/pid_cell.sv
// ----------------------------------------------------------------------------
// pid_cell
// one storage cell: takes the left or right neighbor word on a shift,
// the new word on an insert at its own index, and compares for searches
// ----------------------------------------------------------------------------
module pid_cell (
   input  logic                          clock,
   input  pid_pkg::cell_ctrl_type        ctrl,
   input  logic [pid_pkg::CNT_WIDTH-1:0] idx,
   input  logic [pid_pkg::DATA_WIDTH-1:0] left_data,
   input  logic [pid_pkg::DATA_WIDTH-1:0] right_data,
   output logic [pid_pkg::DATA_WIDTH-1:0] data,
   output logic                          hit
);
   import pid_pkg::*;

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;
   logic [CNT_WIDTH-1:0]  idx_next;

   assign idx_next = idx + CNT_WIDTH'(1);

   always_comb begin
      data_in = data_ff;
      if (ctrl.ins) begin
         if (idx == ctrl.pos) begin
            data_in = ctrl.value;
         end else if (idx > ctrl.pos && idx <= ctrl.count) begin
            data_in = left_data;
         end
      end else if (ctrl.rem) begin
         if (idx >= ctrl.pos && idx_next < ctrl.count) begin
            data_in = right_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;
   assign hit  = (idx < ctrl.count) && (data_ff == ctrl.value);

endmodule

### hdl/positional_insert_delete_array_core.sv
// ----------------------------------------------------------------------------
// positional_insert_delete_array_core
// ordered array of words with positional insert, remove, read and search
// ----------------------------------------------------------------------------
// Inserts, removes, reads and unknown codes give their result strobe in the
// cycle after start while busy stays low, so a request can be issued every
// cycle. The row of cells shifts all entries at once.
// Find-first holds busy for one cycle and gives one result. Find-all holds
// busy while it walks the matching entries (one cycle when nothing matches),
// giving its results on consecutive cycles with last on the final one; the
// match vector from the cell compares is walked one hit per cycle. Results
// are shown for one cycle only and cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module positional_insert_delete_array_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [pid_pkg::OP_WIDTH-1:0]   req_op,
   input  logic [pid_pkg::POS_WIDTH-1:0]  req_position,
   input  logic [pid_pkg::DATA_WIDTH-1:0] req_value,
   output logic                           rsp_valid,
   output logic [pid_pkg::DATA_WIDTH-1:0] rsp_data,
   output logic [pid_pkg::IDX_WIDTH-1:0]  rsp_match_index,
   output logic [pid_pkg::ST_WIDTH-1:0]   rsp_status,
   output logic [pid_pkg::CNT_WIDTH-1:0]  rsp_fill_count,
   output logic                           rsp_is_empty,
   output logic                           rsp_is_full,
   output logic                           rsp_last
);
   import pid_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_SCAN = 2'b10
   } state_type;

   localparam logic [CNT_WIDTH-1:0] CAP_COUNT = CNT_WIDTH'(CAPACITY);

   state_type             state_ff, state_in;
   logic [CNT_WIDTH-1:0]  count_ff, count_in;
   logic [CAPACITY-1:0]   hits_ff, hits_in;
   logic                  find_all_ff, find_all_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0] rsp_data_ff, rsp_data_in;
   logic [IDX_WIDTH-1:0]  rsp_index_ff, rsp_index_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [CNT_WIDTH-1:0]  rsp_count_ff;
   logic                  rsp_last_ff, rsp_last_in;

   cell_ctrl_type         ctrl;
   logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
   logic [CAPACITY-1:0]   cell_hit;
   logic                  accept;
   logic [CAPACITY-1:0]   low_bit;
   logic [CAPACITY-1:0]   hits_rest;
   logic [IDX_WIDTH-1:0]  low_index;

   assign accept = start && (state_ff == S_IDLE);

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_data;
      logic [DATA_WIDTH-1:0] right_data;
      if (i == 0) begin : g_first
         assign left_data = '0;
      end else begin : g_mid_l
         assign left_data = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_mid_r
         assign right_data = cell_data[i+1];
      end
      pid_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .idx        (CNT_WIDTH'(i)),
         .left_data  (left_data),
         .right_data (right_data),
         .data       (cell_data[i]),
         .hit        (cell_hit[i])
      );
   end

   // lowest pending hit
   assign low_bit   = hits_ff & (~hits_ff + CAPACITY'(1));
   assign hits_rest = hits_ff & ~low_bit;

   always_comb begin
      low_index = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (low_bit[i]) begin
            low_index = low_index | IDX_WIDTH'(i);
         end
      end
   end

   always_comb begin
      ctrl.ins      = 1'b0;
      ctrl.rem      = 1'b0;
      ctrl.pos      = req_position;
      ctrl.count    = count_ff;
      ctrl.value    = req_value;
      state_in      = state_ff;
      hits_in       = hits_ff;
      find_all_in   = find_all_ff;
      rsp_valid_in  = 1'b0;
      rsp_data_in   = '0;
      rsp_index_in  = '0;
      rsp_status_in = STATUS_OK;
      rsp_last_in   = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               unique case (req_op)
                  OP_INSERT_AT: begin
                     if (req_position > count_ff) begin
                        rsp_status_in = STATUS_BAD_POS;
                     end else if (count_ff == CAP_COUNT) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        ctrl.ins = 1'b1;
                     end
                  end
                  OP_INSERT_FRONT, OP_INSERT_BACK: begin
                     ctrl.pos = (req_op == OP_INSERT_FRONT) ? '0 : count_ff;
                     if (count_ff == CAP_COUNT) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        ctrl.ins = 1'b1;
                     end
                  end
                  OP_REMOVE_AT: begin
                     if (req_position >= count_ff) begin
                        rsp_status_in = STATUS_BAD_POS;
                     end else begin
                        ctrl.rem = 1'b1;
                     end
                  end
                  OP_REMOVE_FRONT, OP_REMOVE_BACK: begin
                     ctrl.pos = (req_op == OP_REMOVE_FRONT) ? '0
                                                            : count_ff - CNT_WIDTH'(1);
                     if (count_ff == '0) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        ctrl.rem = 1'b1;
                     end
                  end
                  OP_READ: begin
                     if (req_position >= count_ff) begin
                        rsp_status_in = STATUS_BAD_POS;
                     end else begin
                        rsp_data_in = cell_data[req_position[IDX_WIDTH-1:0]];
                     end
                  end
                  OP_FIND_FIRST, OP_FIND_ALL: begin
                     rsp_valid_in = 1'b0;
                     hits_in      = cell_hit;
                     find_all_in  = (req_op == OP_FIND_ALL);
                     state_in     = S_SCAN;
                  end
                  default: begin
                     rsp_status_in = STATUS_BAD_POS;
                  end
               endcase
            end
         end
         S_SCAN: begin
            rsp_valid_in = 1'b1;
            if (hits_ff == '0) begin
               rsp_status_in = STATUS_NOT_FOUND;
               state_in      = S_IDLE;
            end else begin
               rsp_index_in = low_index;
               rsp_last_in  = !find_all_ff || (hits_rest == '0);
               hits_in      = hits_rest;
               if (rsp_last_in) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      count_in = count_ff;
      if (ctrl.ins) begin
         count_in = count_ff + CNT_WIDTH'(1);
      end else if (ctrl.rem) begin
         count_in = count_ff - CNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hits_ff       <= hits_in;
      find_all_ff   <= find_all_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign busy            = (state_ff == S_SCAN);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;
   assign rsp_match_index = rsp_index_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_fill_count  = rsp_count_ff;
   assign rsp_is_empty    = (rsp_count_ff == '0);
   assign rsp_is_full     = (rsp_count_ff == CAP_COUNT);
   assign rsp_last        = rsp_last_ff;

endmodule

### hdl/pid_checker.sv
// ----------------------------------------------------------------------------
// pid_checker
// port-level checks for the positional insert/delete array
// ----------------------------------------------------------------------------
module pid_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic [pid_pkg::OP_WIDTH-1:0]   req_op,
   input logic                           rsp_valid,
   input logic [pid_pkg::CNT_WIDTH-1:0]  rsp_fill_count,
   input logic                           rsp_is_empty,
   input logic                           rsp_is_full,
   input logic                           rsp_last
);
   import pid_pkg::*;

   // requests other than searches answer in the next cycle
   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_op != OP_FIND_FIRST && req_op != OP_FIND_ALL
      |=> rsp_valid && rsp_last)
      else $error("single-result request not answered in next cycle");

   // search results run back to back until last
   a_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_valid)
      else $error("gap inside a search result burst");

   a_burst_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> busy)
      else $error("busy low while search results remain");

   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (rsp_fill_count == '0)) &&
                    (rsp_is_full == (rsp_fill_count == CNT_WIDTH'(CAPACITY))))
      else $error("empty/full flags disagree with fill count");

endmodule

bind positional_insert_delete_array_core pid_checker u_pid_checker (.*);
